// ===== hdl/mnrt_pkg.sv =====
// shared types and constants for the mesh neighbor and route table
package mnrt_pkg;

    localparam int NODE_W      = 8;
    localparam int WEIGHT_W    = 10;
    localparam int HOPS_W      = 8;
    localparam int FUNC_W      = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [WEIGHT_W-1:0] HEARD_STEP = WEIGHT_W'(10);

    localparam logic [NODE_W-1:0]   RST_OWN_ADDRESS     = NODE_W'(0);
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CEILING  = WEIGHT_W'(100);
    localparam logic [WEIGHT_W-1:0] RST_TRUST_THRESHOLD = WEIGHT_W'(50);
    localparam logic [HOPS_W-1:0]   RST_HOP_LIMIT       = HOPS_W'(8);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_HEARD  = 3'd0,
        FUNC_TICK   = 3'd1,
        FUNC_LEARN  = 3'd2,
        FUNC_PURGE  = 3'd3,
        FUNC_LOOKUP = 3'd4
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OWN_ADDRESS     = 2'd0,
        CFG_WEIGHT_CEILING  = 2'd1,
        CFG_TRUST_THRESHOLD = 2'd2,
        CFG_HOP_LIMIT       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [NODE_W-1:0]   node;
        logic [WEIGHT_W-1:0] weight;
        logic                trust;
        logic [NODE_W-1:0]   via;
        logic [HOPS_W-1:0]   hops;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [NODE_W-1:0]   own_address;
        logic [WEIGHT_W-1:0] weight_ceiling;
        logic [WEIGHT_W-1:0] trust_threshold;
        logic [HOPS_W-1:0]   hop_limit;
    } cfg_regs_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_TICK_WR,
        ST_TICK_PURGE,
        ST_TICK_RD,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/mnrt_ram.sv =====
// generic single-write single-read ram with registered read, write-first
module mnrt_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr)) begin
            rdata <= wdata;
        end else begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/mnrt_cfg.sv =====
// configuration register file
module mnrt_cfg (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mnrt_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [mnrt_pkg::CFG_DATA_W-1:0]        cfg_data,
    output mnrt_pkg::cfg_regs_t                    cfg_regs
);

    mnrt_pkg::cfg_regs_t regs_reg;
    mnrt_pkg::cfg_regs_t regs_next;

    assign cfg_ready = 1'b1;
    assign cfg_regs  = regs_reg;

    always_comb begin
        regs_next = regs_reg;
        if (cfg_valid) begin
            case (cfg_index)
                mnrt_pkg::CFG_OWN_ADDRESS: begin
                    regs_next.own_address = cfg_data[mnrt_pkg::NODE_W-1:0];
                end
                mnrt_pkg::CFG_WEIGHT_CEILING: begin
                    regs_next.weight_ceiling = cfg_data[mnrt_pkg::WEIGHT_W-1:0];
                end
                mnrt_pkg::CFG_TRUST_THRESHOLD: begin
                    regs_next.trust_threshold = cfg_data[mnrt_pkg::WEIGHT_W-1:0];
                end
                mnrt_pkg::CFG_HOP_LIMIT: begin
                    regs_next.hop_limit = cfg_data[mnrt_pkg::HOPS_W-1:0];
                end
                default: begin
                    regs_next = regs_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            regs_reg.own_address     <= mnrt_pkg::RST_OWN_ADDRESS;
            regs_reg.weight_ceiling  <= mnrt_pkg::RST_WEIGHT_CEILING;
            regs_reg.trust_threshold <= mnrt_pkg::RST_TRUST_THRESHOLD;
            regs_reg.hop_limit       <= mnrt_pkg::RST_HOP_LIMIT;
        end else begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/mnrt_engine.sv =====
// table sequencer: sweeps, read-modify-write and result register
module mnrt_engine #(
    parameter int TABLE_ENTRIES = 16,
    localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  mnrt_pkg::cfg_regs_t               cfg,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mnrt_pkg::FUNC_W-1:0]       s_func,
    input  logic [mnrt_pkg::NODE_W-1:0]       s_node,
    input  logic [mnrt_pkg::HOPS_W-1:0]       s_hops,
    input  logic [mnrt_pkg::NODE_W-1:0]       s_via,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_trusted,
    output logic [mnrt_pkg::NODE_W-1:0]       m_next_hop,
    output logic                              ram_we,
    output logic [IDX_W-1:0]                  ram_waddr,
    output mnrt_pkg::entry_t                  ram_wdata,
    output logic [IDX_W-1:0]                  ram_raddr,
    input  mnrt_pkg::entry_t                  ram_rdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    mnrt_pkg::state_t                  state_reg, state_next;
    logic [mnrt_pkg::FUNC_W-1:0]       func_reg, func_next;
    logic [mnrt_pkg::NODE_W-1:0]       node_reg, node_next;
    logic [mnrt_pkg::HOPS_W-1:0]       hops_reg, hops_next;
    logic [mnrt_pkg::NODE_W-1:0]       via_reg, via_next;
    logic [IDX_W-1:0]                  idx_reg, idx_next;
    logic [IDX_W-1:0]                  tick_idx_reg, tick_idx_next;
    logic [mnrt_pkg::NODE_W-1:0]       pnode_reg, pnode_next;
    logic [TABLE_ENTRIES-1:0]          valid_reg, valid_next;
    logic [TABLE_ENTRIES-1:0]          written_reg, written_next;
    logic                              found_reg, found_next;
    logic [IDX_W-1:0]                  found_idx_reg, found_idx_next;
    mnrt_pkg::entry_t                  found_word_reg, found_word_next;
    logic                              free_reg, free_next;
    logic [IDX_W-1:0]                  free_idx_reg, free_idx_next;
    mnrt_pkg::entry_t                  free_word_reg, free_word_next;
    logic                              any_reg, any_next;
    logic                              any_trust_reg, any_trust_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              m_trusted_reg, m_trusted_next;
    logic [mnrt_pkg::NODE_W-1:0]       m_next_hop_reg, m_next_hop_next;

    mnrt_pkg::entry_t                  cur;
    logic                              cur_valid;
    logic                              node_hit;
    logic                              idx_last;
    logic [IDX_W-1:0]                  idx_inc;
    logic [mnrt_pkg::WEIGHT_W-1:0]     w_dec;
    logic [mnrt_pkg::WEIGHT_W:0]       heard_sum;
    logic [mnrt_pkg::WEIGHT_W-1:0]     heard_weight;
    logic [mnrt_pkg::HOPS_W:0]         h1;
    logic                              learn_ok;

    // entries never written read as zero
    assign cur       = written_reg[idx_reg] ? ram_rdata : '0;
    assign cur_valid = valid_reg[idx_reg];
    assign node_hit  = (cur.node == node_reg);
    assign idx_last  = (idx_reg == LAST_IDX);
    assign idx_inc   = idx_last ? '0 : idx_reg + 1'b1;
    assign w_dec     = (cur.weight == '0) ? '0 : cur.weight - 1'b1;

    assign heard_sum    = {1'b0, found_word_reg.weight} + {1'b0, mnrt_pkg::HEARD_STEP};
    assign heard_weight = (heard_sum > {1'b0, cfg.weight_ceiling}) ?
                          cfg.weight_ceiling : heard_sum[mnrt_pkg::WEIGHT_W-1:0];
    assign h1           = {1'b0, hops_reg} + 1'b1;

    assign learn_ok = (s_node != '0) && (s_node != cfg.own_address) && (s_hops < cfg.hop_limit);

    assign m_valid    = m_valid_reg;
    assign m_trusted  = m_trusted_reg;
    assign m_next_hop = m_next_hop_reg;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        node_next       = node_reg;
        hops_next       = hops_reg;
        via_next        = via_reg;
        idx_next        = idx_reg;
        tick_idx_next   = tick_idx_reg;
        pnode_next      = pnode_reg;
        valid_next      = valid_reg;
        written_next    = written_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_word_next = found_word_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        free_word_next  = free_word_reg;
        any_next        = any_reg;
        any_trust_next  = any_trust_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_trusted_next  = m_trusted_reg;
        m_next_hop_next = m_next_hop_reg;
        s_ready         = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = cur;
        ram_raddr       = idx_inc;

        case (state_reg)
            mnrt_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = '0;
                if (s_valid) begin
                    func_next  = s_func;
                    node_next  = s_node;
                    hops_next  = s_hops;
                    via_next   = s_via;
                    idx_next   = '0;
                    found_next = 1'b0;
                    free_next  = 1'b0;
                    any_next   = 1'b0;
                    case (s_func)
                        mnrt_pkg::FUNC_HEARD,
                        mnrt_pkg::FUNC_PURGE,
                        mnrt_pkg::FUNC_LOOKUP: state_next = mnrt_pkg::ST_SCAN;
                        mnrt_pkg::FUNC_LEARN: begin
                            state_next = learn_ok ? mnrt_pkg::ST_SCAN : mnrt_pkg::ST_DONE;
                        end
                        mnrt_pkg::FUNC_TICK: state_next = mnrt_pkg::ST_TICK_WR;
                        default: state_next = mnrt_pkg::ST_DONE;
                    endcase
                end
            end

            mnrt_pkg::ST_SCAN: begin
                if ((func_reg == mnrt_pkg::FUNC_PURGE) && cur_valid && (cur.via == via_reg)) begin
                    valid_next[idx_reg] = 1'b0;
                end
                if (!found_reg && cur_valid && node_hit) begin
                    found_next      = 1'b1;
                    found_idx_next  = idx_reg;
                    found_word_next = cur;
                end
                if (!free_reg && !cur_valid) begin
                    free_next      = 1'b1;
                    free_idx_next  = idx_reg;
                    free_word_next = cur;
                end
                if (!any_reg && node_hit) begin
                    any_next       = 1'b1;
                    any_trust_next = cur.trust;
                end
                idx_next = idx_inc;
                if (idx_last) begin
                    if ((func_reg == mnrt_pkg::FUNC_HEARD) || (func_reg == mnrt_pkg::FUNC_LEARN)) begin
                        state_next = mnrt_pkg::ST_UPDATE;
                    end else begin
                        state_next = mnrt_pkg::ST_DONE;
                    end
                end
            end

            mnrt_pkg::ST_UPDATE: begin
                if (func_reg == mnrt_pkg::FUNC_HEARD) begin
                    if (found_reg) begin
                        ram_we           = 1'b1;
                        ram_waddr        = found_idx_reg;
                        ram_wdata        = found_word_reg;
                        ram_wdata.weight = heard_weight;
                        ram_wdata.via    = '0;
                        ram_wdata.hops   = mnrt_pkg::HOPS_W'(1);
                    end else if (free_reg) begin
                        ram_we           = 1'b1;
                        ram_waddr        = free_idx_reg;
                        ram_wdata.node   = node_reg;
                        ram_wdata.weight = mnrt_pkg::HEARD_STEP;
                        ram_wdata.trust  = free_word_reg.trust;
                        ram_wdata.via    = '0;
                        ram_wdata.hops   = mnrt_pkg::HOPS_W'(1);
                        valid_next[free_idx_reg] = 1'b1;
                    end
                end else begin
                    if (found_reg) begin
                        if (({1'b0, found_word_reg.hops} > h1) || !found_word_reg.trust) begin
                            ram_we         = 1'b1;
                            ram_waddr      = found_idx_reg;
                            ram_wdata      = found_word_reg;
                            ram_wdata.via  = via_reg;
                            ram_wdata.hops = h1[mnrt_pkg::HOPS_W-1:0];
                        end
                    end else if (free_reg) begin
                        ram_we           = 1'b1;
                        ram_waddr        = free_idx_reg;
                        ram_wdata.node   = node_reg;
                        ram_wdata.weight = free_word_reg.weight;
                        ram_wdata.trust  = 1'b1;
                        ram_wdata.via    = via_reg;
                        ram_wdata.hops   = h1[mnrt_pkg::HOPS_W-1:0];
                        valid_next[free_idx_reg] = 1'b1;
                    end
                end
                state_next = mnrt_pkg::ST_DONE;
            end

            mnrt_pkg::ST_TICK_WR: begin
                ram_we           = 1'b1;
                ram_wdata.weight = w_dec;
                if (cur_valid && (cur.via == '0)) begin
                    if (w_dec == '0) begin
                        valid_next[idx_reg] = 1'b0;
                    end else if (w_dec > cfg.trust_threshold) begin
                        ram_wdata.trust = 1'b1;
                    end else begin
                        ram_wdata.trust = 1'b0;
                    end
                end
                if (cur_valid && (cur.via == '0) && (w_dec != '0)
                        && (w_dec <= cfg.trust_threshold)) begin
                    // untrusted neighbor: sweep out its routes
                    pnode_next    = cur.node;
                    tick_idx_next = idx_reg;
                    idx_next      = '0;
                    ram_raddr     = '0;
                    state_next    = mnrt_pkg::ST_TICK_PURGE;
                end else if (idx_last) begin
                    state_next = mnrt_pkg::ST_DONE;
                end else begin
                    idx_next = idx_inc;
                end
            end

            mnrt_pkg::ST_TICK_PURGE: begin
                if (cur_valid && (cur.via == pnode_reg)) begin
                    valid_next[idx_reg] = 1'b0;
                end
                idx_next = idx_inc;
                if (idx_last) begin
                    if (tick_idx_reg == LAST_IDX) begin
                        state_next = mnrt_pkg::ST_DONE;
                    end else begin
                        idx_next   = tick_idx_reg + 1'b1;
                        state_next = mnrt_pkg::ST_TICK_RD;
                    end
                end
            end

            mnrt_pkg::ST_TICK_RD: begin
                ram_raddr  = idx_reg;
                state_next = mnrt_pkg::ST_TICK_WR;
            end

            mnrt_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_trusted_next  = (func_reg == mnrt_pkg::FUNC_HEARD) &&
                                      (found_reg ? any_trust_reg :
                                                   (free_reg && free_word_reg.trust));
                    if ((func_reg == mnrt_pkg::FUNC_LOOKUP) && found_reg) begin
                        m_next_hop_next = (found_word_reg.via == '0) ? node_reg :
                                                                       found_word_reg.via;
                    end else begin
                        m_next_hop_next = '0;
                    end
                    state_next = mnrt_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mnrt_pkg::ST_IDLE;
            end
        endcase

        if (ram_we) begin
            written_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mnrt_pkg::ST_IDLE;
            valid_reg   <= '0;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            written_reg <= written_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        node_reg       <= node_next;
        hops_reg       <= hops_next;
        via_reg        <= via_next;
        idx_reg        <= idx_next;
        tick_idx_reg   <= tick_idx_next;
        pnode_reg      <= pnode_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_word_reg <= found_word_next;
        free_reg       <= free_next;
        free_idx_reg   <= free_idx_next;
        free_word_reg  <= free_word_next;
        any_reg        <= any_next;
        any_trust_reg  <= any_trust_next;
        m_trusted_reg  <= m_trusted_next;
        m_next_hop_reg <= m_next_hop_next;
    end

`ifndef SYNTHESIS
    a_write_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == mnrt_pkg::ST_UPDATE) || (state_reg == mnrt_pkg::ST_TICK_WR))
        else $error("table write outside an update phase");

    a_valid_written: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg & ~written_reg) == '0)
        else $error("valid entry that was never written");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != mnrt_pkg::ST_IDLE))
        else $error("accepted transaction did not start");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == mnrt_pkg::ST_DONE))
        else $error("result raised outside the done state");
`endif

endmodule

// ===== hdl/mesh_neighbor_route_table.sv =====
// Mesh neighbor and route table, top level.
// Input channel s_*: one transaction per operation. s_tuser carries the
// operation (heard, tick, learn, purge, lookup); s_tdata carries node_id,
// hop_count and via_neighbor. Every input transaction gives exactly one
// result transaction on m_*: is_trusted (heard) and next_hop (lookup).
// Configuration channel cfg_*: register writes, always ready; write only
// while the table is idle.
// The table lives in one ram with a registered read; valid and written
// flags are flip-flops. Each operation but a rejected learn or an unused
// code is a sweep of that ram, one entry per cycle. Heard and an accepted
// learn then write back in an update step. A tick pauses its sweep for
// a further sweep over the whole table for every direct neighbor whose
// weight falls to or below the trust threshold but not to zero, to sweep
// out its routes. The result appears in the cycle in which s_tready is
// back high.
// One operation is handled at a time; s_tready is high while idle.
// The result sits in an output register: the next operation is accepted
// while it waits, and finishes only once m_tready has taken the earlier one.
// Reset (aresetn low, synchronous) empties the table at once and restores
// the register defaults; no clearing pass is needed.
module mesh_neighbor_route_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // node_id, hop_count, via_neighbor
    input  logic [mnrt_pkg::FUNC_W-1:0]         s_tuser,  // func
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // is_trusted, next_hop, zero pad
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mnrt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mnrt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    mnrt_pkg::cfg_regs_t             cfg_regs;
    logic                            ram_we;
    logic [IDX_W-1:0]                ram_waddr;
    mnrt_pkg::entry_t                ram_wdata;
    logic [IDX_W-1:0]                ram_raddr;
    mnrt_pkg::entry_t                ram_rdata;
    logic                            m_trusted;
    logic [mnrt_pkg::NODE_W-1:0]     m_next_hop;

    assign m_tdata = {7'b0, m_next_hop, m_trusted};

    mnrt_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    mnrt_ram #(
        .WIDTH (mnrt_pkg::ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mnrt_engine #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_regs),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_func     (s_tuser),
        .s_node     (s_tdata[7:0]),
        .s_hops     (s_tdata[15:8]),
        .s_via      (s_tdata[23:16]),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_trusted  (m_trusted),
        .m_next_hop (m_next_hop),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule
